// ----- design/arc_pkg.sv -----
// arc_pkg: shared types and codes of the arp resolver cache
// holds word structs, action/command codes and the controller-datapath interface
// no dependencies
package arc_pkg;

    // input word, one parsed item
    typedef struct packed {
        logic [1:0]  cmd;
        logic [31:0] hop_ip;
        logic [15:0] datagram_handle;
        logic [47:0] frame_dst_mac;
        logic [15:0] ether_type;
        logic        parse_ok;
        logic [15:0] arp_opcode;
        logic [47:0] arp_sender_mac;
        logic [31:0] arp_sender_ip;
        logic [31:0] arp_target_ip;
        logic [31:0] elapsed_ms;
    } t_in_word;

    // output word, one result
    typedef struct packed {
        logic [2:0]  action;
        logic [47:0] dst_mac;
        logic [31:0] target_ip;
        logic [15:0] out_handle;
        logic        last;
    } t_out_word;

    // input commands
    localparam logic [1:0] CMD_SEND = 2'd0;
    localparam logic [1:0] CMD_RX   = 2'd1;
    localparam logic [1:0] CMD_TICK = 2'd2;
    localparam logic [1:0] CMD_RSVD = 2'd3;

    // result actions
    localparam logic [2:0] ACT_NONE    = 3'd0;
    localparam logic [2:0] ACT_IPV4    = 3'd1;
    localparam logic [2:0] ACT_REQUEST = 3'd2;
    localparam logic [2:0] ACT_REPLY   = 3'd3;
    localparam logic [2:0] ACT_DELIVER = 3'd4;
    localparam logic [2:0] ACT_DROP    = 3'd5;

    // register indexes
    localparam logic [1:0] CFG_MY_MAC   = 2'd0;
    localparam logic [1:0] CFG_MY_IP    = 2'd1;
    localparam logic [1:0] CFG_REQ_WAIT = 2'd2;
    localparam logic [1:0] CFG_TTL      = 2'd3;

    localparam logic [15:0] ETH_IPV4     = 16'h0800;
    localparam logic [15:0] ETH_ARP      = 16'h0806;
    localparam logic [15:0] ARP_OP_REQ   = 16'd1;
    localparam logic [15:0] ARP_OP_REPLY = 16'd2;
    localparam logic [47:0] BCAST_MAC    = 48'hFFFF_FFFF_FFFF;
    localparam logic [15:0] RESET_WAIT   = 16'd5000;
    localparam logic [31:0] RESET_TTL    = 32'd5000;

    // scan index width, covers the largest table
    localparam int SCAN_W = 8;

    // datapath operations
    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_DISP,
        OP_CS_SEND,
        OP_CS_LEARN,
        OP_CS_AGE,
        OP_RS_SEND,
        OP_RS_AGE,
        OP_SEND,
        OP_LEARN,
        OP_FLUSH,
        OP_QDROP,
        OP_COMPACT,
        OP_CFIN,
        OP_RCLR,
        OP_DONE
    } t_dp_op;

    typedef struct packed {
        t_dp_op              op;
        logic [SCAN_W-1:0]   idx;
    } t_dp_cmd;

    typedef struct packed {
        logic       out_free;
        logic [1:0] cmd;
        logic       rx_ok;
        logic       is_arp;
    } t_dp_stat;

endpackage

// ----- design/arc_ctrl.sv -----
// arc_ctrl: sequencer of the arp resolver cache
// walks the table scans for each command; depends on arc_pkg
module arc_ctrl import arc_pkg::*; #(
    parameter int CACHE_ENTRIES   = 16,
    parameter int REQUEST_ENTRIES = 8,
    parameter int QUEUE_DEPTH     = 16
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_stall,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd
);

    typedef enum logic [11:0] {
        S_IDLE    = 12'b0000_0000_0001,
        S_DISP    = 12'b0000_0000_0010,
        S_CSCAN   = 12'b0000_0000_0100,
        S_RSCAN   = 12'b0000_0000_1000,
        S_SEND    = 12'b0000_0001_0000,
        S_LEARN   = 12'b0000_0010_0000,
        S_FLUSH   = 12'b0000_0100_0000,
        S_QDROP   = 12'b0000_1000_0000,
        S_COMPACT = 12'b0001_0000_0000,
        S_CFIN    = 12'b0010_0000_0000,
        S_RCLR    = 12'b0100_0000_0000,
        S_DONE    = 12'b1000_0000_0000
    } t_state;

    localparam logic [SCAN_W-1:0] C_LAST = SCAN_W'(CACHE_ENTRIES - 1);
    localparam logic [SCAN_W-1:0] R_LAST = SCAN_W'(REQUEST_ENTRIES - 1);
    localparam logic [SCAN_W-1:0] Q_LAST = SCAN_W'(QUEUE_DEPTH - 1);

    t_state            r_state, n_state;
    logic [SCAN_W-1:0] r_idx, n_idx;

    // next state and datapath command
    always_comb begin
        n_state    = r_state;
        n_idx      = r_idx;
        o_cmd.op   = OP_NONE;
        o_cmd.idx  = r_idx;
        o_in_stall = (r_state != S_IDLE);
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.op = OP_LOAD;
                    n_state  = S_DISP;
                end
            end
            S_DISP: begin
                if (i_stat.out_free) begin
                    o_cmd.op = OP_DISP;
                    n_idx    = '0;
                    priority if (i_stat.cmd == CMD_SEND || i_stat.cmd == CMD_TICK)
                        n_state = S_CSCAN;
                    else if (i_stat.cmd == CMD_RX && i_stat.rx_ok && i_stat.is_arp)
                        n_state = S_CSCAN;
                    else
                        n_state = S_DONE;
                end
            end
            S_CSCAN: begin
                if (i_stat.out_free) begin
                    priority if (i_stat.cmd == CMD_SEND) o_cmd.op = OP_CS_SEND;
                    else if (i_stat.cmd == CMD_RX)       o_cmd.op = OP_CS_LEARN;
                    else                                 o_cmd.op = OP_CS_AGE;
                    if (r_idx == C_LAST) begin
                        n_idx   = '0;
                        n_state = (i_stat.cmd == CMD_RX) ? S_LEARN : S_RSCAN;
                    end else begin
                        n_idx = r_idx + 1'b1;
                    end
                end
            end
            S_RSCAN: begin
                if (i_stat.out_free) begin
                    o_cmd.op = (i_stat.cmd == CMD_SEND) ? OP_RS_SEND : OP_RS_AGE;
                    if (r_idx == R_LAST) begin
                        n_idx   = '0;
                        n_state = (i_stat.cmd == CMD_SEND) ? S_SEND : S_QDROP;
                    end else begin
                        n_idx = r_idx + 1'b1;
                    end
                end
            end
            S_SEND: begin
                if (i_stat.out_free) begin
                    o_cmd.op = OP_SEND;
                    n_state  = S_DONE;
                end
            end
            S_LEARN: begin
                if (i_stat.out_free) begin
                    o_cmd.op = OP_LEARN;
                    n_idx    = '0;
                    n_state  = S_FLUSH;
                end
            end
            S_FLUSH, S_QDROP, S_COMPACT: begin
                if (i_stat.out_free) begin
                    priority if (r_state == S_FLUSH) o_cmd.op = OP_FLUSH;
                    else if (r_state == S_QDROP)     o_cmd.op = OP_QDROP;
                    else                             o_cmd.op = OP_COMPACT;
                    if (r_idx == Q_LAST) begin
                        n_idx   = '0;
                        n_state = (r_state == S_COMPACT) ? S_CFIN : S_COMPACT;
                    end else begin
                        n_idx = r_idx + 1'b1;
                    end
                end
            end
            S_CFIN: begin
                if (i_stat.out_free) begin
                    o_cmd.op = OP_CFIN;
                    n_state  = (i_stat.cmd == CMD_RX) ? S_RCLR : S_DONE;
                end
            end
            S_RCLR: begin
                if (i_stat.out_free) begin
                    o_cmd.op = OP_RCLR;
                    n_state  = S_DONE;
                end
            end
            S_DONE: begin
                if (i_stat.out_free) begin
                    o_cmd.op = OP_DONE;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
        end
    end

endmodule

// ----- design/arc_dp.sv -----
// arc_dp: tables, scan registers and result buffers of the arp resolver cache
// executes one command per cycle from arc_ctrl; depends on arc_pkg
module arc_dp import arc_pkg::*; #(
    parameter int CACHE_ENTRIES   = 16,
    parameter int REQUEST_ENTRIES = 8,
    parameter int QUEUE_DEPTH     = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_in_word    i_in_word,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [47:0] i_cfg_data,
    input  t_dp_cmd     i_cmd,
    output t_dp_stat    o_stat,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output t_out_word   o_out_word
);

    localparam int CW = (CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1;
    localparam int RW = (REQUEST_ENTRIES > 1) ? $clog2(REQUEST_ENTRIES) : 1;
    localparam int QW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam logic [QW:0] Q_N = (QW+1)'(QUEUE_DEPTH);

    // configuration
    logic [47:0] r_my_mac;
    logic [31:0] r_my_ip;
    logic [15:0] r_req_wait;
    logic [31:0] r_entry_ttl;

    // tables
    logic [CACHE_ENTRIES-1:0]   r_c_vld;
    logic [31:0]                r_c_ip  [CACHE_ENTRIES];
    logic [47:0]                r_c_mac [CACHE_ENTRIES];
    logic [31:0]                r_c_ttl [CACHE_ENTRIES];
    logic [REQUEST_ENTRIES-1:0] r_r_vld;
    logic [REQUEST_ENTRIES-1:0] r_r_exp;
    logic [31:0]                r_r_ip  [REQUEST_ENTRIES];
    logic [15:0]                r_r_ttl [REQUEST_ENTRIES];
    logic [QUEUE_DEPTH-1:0]     r_q_vld;
    logic [31:0]                r_q_ip  [QUEUE_DEPTH];
    logic [15:0]                r_q_h   [QUEUE_DEPTH];
    logic [QW-1:0]              r_head, r_tail;

    // item and scan results
    t_in_word    r_in;
    logic        r_m_found, r_f_found, r_pend, r_rf_found, r_cp_found;
    logic [CW-1:0] r_m_idx, r_f_idx, r_min_idx;
    logic [31:0] r_min_ttl;
    logic [47:0] r_hit_mac;
    logic [RW-1:0] r_rf_idx;
    logic [QW-1:0] r_cp_pos;

    // result buffers
    logic        r_hold_vld, r_out_vld;
    t_out_word   r_hold, r_out;

    logic [CW-1:0] ci;
    logic [RW-1:0] ri;
    logic [QW-1:0] qp, n_tail;
    logic [QW:0]   qsum, tsum;
    logic [31:0]   c_ip, c_ttl;
    logic [47:0]   c_mac;
    logic          c_vld, r_vld_s, q_vld_s, q_match, drop_hit;
    logic [31:0]   r_ip_s, q_ip_s;
    logic [15:0]   r_ttl_s, q_h_s;
    logic          rx_ok, is_ipv4, is_arp, reply;
    logic          emit, out_load, scan0;
    t_out_word     emit_word, n_out;
    logic [CW-1:0] pick;
    logic          send_drop;

    // per-cycle table reads at the scan index
    always_comb begin
        ci      = i_cmd.idx[CW-1:0];
        ri      = i_cmd.idx[RW-1:0];
        qsum    = (QW+1)'(r_head) + (QW+1)'(i_cmd.idx[QW-1:0]);
        qp      = (qsum >= Q_N) ? QW'(qsum - Q_N) : qsum[QW-1:0];
        tsum    = (QW+1)'(r_tail) + (QW+1)'(1);
        n_tail  = (tsum >= Q_N) ? QW'(tsum - Q_N) : tsum[QW-1:0];
        scan0   = (i_cmd.idx == '0);
        c_vld   = r_c_vld[ci];
        c_ip    = r_c_ip[ci];
        c_mac   = r_c_mac[ci];
        c_ttl   = r_c_ttl[ci];
        r_vld_s = r_r_vld[ri];
        r_ip_s  = r_r_ip[ri];
        r_ttl_s = r_r_ttl[ri];
        q_vld_s = r_q_vld[qp];
        q_ip_s  = r_q_ip[qp];
        q_h_s   = r_q_h[qp];
        q_match = q_vld_s && (q_ip_s == r_in.arp_sender_ip);
        drop_hit = 1'b0;
        for (int i = 0; i < REQUEST_ENTRIES; i++) begin
            if (r_r_exp[i] && (r_r_ip[i] == q_ip_s)) drop_hit = 1'b1;
        end
    end

    // frame classification
    always_comb begin
        rx_ok   = ((r_in.frame_dst_mac == BCAST_MAC) || (r_in.frame_dst_mac == r_my_mac))
                  && r_in.parse_ok;
        is_ipv4 = (r_in.ether_type == ETH_IPV4);
        is_arp  = (r_in.ether_type == ETH_ARP);
        reply   = (r_in.arp_opcode == ARP_OP_REQ) && (r_in.arp_target_ip == r_my_ip);
        pick    = r_m_found ? r_m_idx : (r_f_found ? r_f_idx : r_min_idx);
        send_drop = r_q_vld[r_tail] || (!r_pend && !r_rf_found);
        o_stat.out_free = !r_out_vld;
        o_stat.cmd      = r_in.cmd;
        o_stat.rx_ok    = rx_ok;
        o_stat.is_arp   = is_arp;
    end

    // result generation
    always_comb begin
        emit      = 1'b0;
        emit_word = '0;
        unique case (i_cmd.op)
            OP_DISP: begin
                if (r_in.cmd == CMD_RX && rx_ok && is_ipv4) begin
                    emit = 1'b1;
                    emit_word.action     = ACT_DELIVER;
                    emit_word.out_handle = r_in.datagram_handle;
                end else if (r_in.cmd == CMD_RX && rx_ok && is_arp && reply) begin
                    emit = 1'b1;
                    emit_word.action    = ACT_REPLY;
                    emit_word.dst_mac   = r_in.arp_sender_mac;
                    emit_word.target_ip = r_in.arp_sender_ip;
                end
            end
            OP_SEND: begin
                emit = 1'b1;
                if (r_m_found) begin
                    emit_word.action     = ACT_IPV4;
                    emit_word.dst_mac    = r_hit_mac;
                    emit_word.out_handle = r_in.datagram_handle;
                end else if (send_drop) begin
                    emit_word.action     = ACT_DROP;
                    emit_word.target_ip  = r_in.hop_ip;
                    emit_word.out_handle = r_in.datagram_handle;
                end else if (!r_pend) begin
                    emit_word.action    = ACT_REQUEST;
                    emit_word.dst_mac   = BCAST_MAC;
                    emit_word.target_ip = r_in.hop_ip;
                end else begin
                    emit = 1'b0;
                end
            end
            OP_FLUSH: begin
                if (q_match) begin
                    emit = 1'b1;
                    emit_word.action     = ACT_IPV4;
                    emit_word.dst_mac    = r_in.arp_sender_mac;
                    emit_word.out_handle = q_h_s;
                end
            end
            default: begin
                emit = 1'b0;
            end
        endcase
        // the held word goes out when a newer one arrives or the item ends
        out_load = 1'b0;
        n_out    = r_hold;
        if (emit && r_hold_vld) begin
            out_load = 1'b1;
        end else if (i_cmd.op == OP_DONE) begin
            out_load   = 1'b1;
            n_out      = r_hold_vld ? r_hold : '0;
            n_out.last = 1'b1;
        end
    end

    // control state with reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_my_mac    <= '0;
            r_my_ip     <= '0;
            r_req_wait  <= RESET_WAIT;
            r_entry_ttl <= RESET_TTL;
            r_c_vld     <= '0;
            r_r_vld     <= '0;
            r_q_vld     <= '0;
            r_head      <= '0;
            r_tail      <= '0;
            r_hold_vld  <= 1'b0;
            r_out_vld   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_MY_MAC:   r_my_mac    <= i_cfg_data;
                    CFG_MY_IP:    r_my_ip     <= i_cfg_data[31:0];
                    CFG_REQ_WAIT: r_req_wait  <= i_cfg_data[15:0];
                    CFG_TTL:      r_entry_ttl <= i_cfg_data[31:0];
                    default:      r_my_mac    <= r_my_mac;
                endcase
            end
            // output register drains on accept
            if (out_load)                         r_out_vld <= 1'b1;
            else if (r_out_vld && !i_out_stall)   r_out_vld <= 1'b0;
            if (emit)                    r_hold_vld <= 1'b1;
            else if (i_cmd.op == OP_DONE) r_hold_vld <= 1'b0;
            unique case (i_cmd.op)
                OP_CS_AGE: begin
                    if (c_vld && c_ttl <= r_in.elapsed_ms) r_c_vld[ci] <= 1'b0;
                end
                OP_RS_AGE: begin
                    if (r_vld_s && {16'd0, r_ttl_s} <= r_in.elapsed_ms) r_r_vld[ri] <= 1'b0;
                end
                OP_SEND: begin
                    if (!r_m_found && !send_drop) begin
                        if (!r_pend) r_r_vld[r_rf_idx] <= 1'b1;
                        r_q_vld[r_tail] <= 1'b1;
                        r_tail          <= n_tail;
                    end
                end
                OP_LEARN: begin
                    r_c_vld[pick] <= 1'b1;
                end
                OP_FLUSH: begin
                    if (q_match) r_q_vld[qp] <= 1'b0;
                end
                OP_QDROP: begin
                    if (q_vld_s && drop_hit) r_q_vld[qp] <= 1'b0;
                end
                OP_CFIN: begin
                    r_head <= r_cp_found ? r_cp_pos : r_tail;
                end
                OP_RCLR: begin
                    for (int i = 0; i < REQUEST_ENTRIES; i++) begin
                        if (r_r_vld[i] && r_r_ip[i] == r_in.arp_sender_ip) r_r_vld[i] <= 1'b0;
                    end
                end
                default: begin
                    r_head <= r_head;
                end
            endcase
        end
    end

    // payload and scan registers
    always_ff @(posedge i_clk) begin
        if (emit)     r_hold <= emit_word;
        if (out_load) r_out  <= n_out;
        unique case (i_cmd.op)
            OP_LOAD: begin
                r_in <= i_in_word;
            end
            OP_DISP: begin
                r_m_found  <= 1'b0;
                r_f_found  <= 1'b0;
                r_pend     <= 1'b0;
                r_rf_found <= 1'b0;
                r_cp_found <= 1'b0;
                r_r_exp    <= '0;
            end
            OP_CS_SEND: begin
                if (c_vld && c_ip == r_in.hop_ip && !r_m_found) begin
                    r_m_found <= 1'b1;
                    r_hit_mac <= c_mac;
                end
            end
            OP_CS_LEARN: begin
                if (c_vld && c_ip == r_in.arp_sender_ip && !r_m_found) begin
                    r_m_found <= 1'b1;
                    r_m_idx   <= ci;
                end
                if (!c_vld && !r_f_found) begin
                    r_f_found <= 1'b1;
                    r_f_idx   <= ci;
                end
                // least remaining lifetime, lowest index on a tie
                if (scan0 || c_ttl < r_min_ttl) begin
                    r_min_ttl <= c_ttl;
                    r_min_idx <= ci;
                end
            end
            OP_CS_AGE: begin
                if (c_vld && c_ttl > r_in.elapsed_ms) r_c_ttl[ci] <= c_ttl - r_in.elapsed_ms;
            end
            OP_RS_SEND: begin
                if (r_vld_s && r_ip_s == r_in.hop_ip) r_pend <= 1'b1;
                if (!r_vld_s && !r_rf_found) begin
                    r_rf_found <= 1'b1;
                    r_rf_idx   <= ri;
                end
            end
            OP_RS_AGE: begin
                if (r_vld_s) begin
                    if ({16'd0, r_ttl_s} <= r_in.elapsed_ms) r_r_exp[ri] <= 1'b1;
                    else r_r_ttl[ri] <= r_ttl_s - r_in.elapsed_ms[15:0];
                end
            end
            OP_SEND: begin
                if (!r_m_found && !send_drop) begin
                    if (!r_pend) begin
                        r_r_ip[r_rf_idx]  <= r_in.hop_ip;
                        r_r_ttl[r_rf_idx] <= r_req_wait;
                    end
                    r_q_ip[r_tail] <= r_in.hop_ip;
                    r_q_h[r_tail]  <= r_in.datagram_handle;
                end
            end
            OP_LEARN: begin
                r_c_ip[pick]  <= r_in.arp_sender_ip;
                r_c_mac[pick] <= r_in.arp_sender_mac;
                r_c_ttl[pick] <= r_entry_ttl;
            end
            OP_COMPACT: begin
                if (q_vld_s && !r_cp_found) begin
                    r_cp_found <= 1'b1;
                    r_cp_pos   <= qp;
                end
            end
            default: begin
                r_cp_pos <= r_cp_pos;
            end
        endcase
    end

    assign o_out_valid = r_out_vld;
    assign o_out_word  = r_out;

endmodule

// ----- design/arp_resolver_cache_top.sv -----
// Resolves IPv4 next hops to Ethernet addresses with a learned cache, a table of
// pending ARP requests and a queue of datagrams waiting for an answer. One input
// word is taken at a time; its results leave one per output word, the final one
// flagged by last. Every table is walked one entry per cycle, while the output
// register is free, by a shared scan counter: a send walks the cache and the
// request table, an accepted ARP frame the cache and then the queue twice, a
// tick the cache, the request table and the queue twice; other words walk no
// table.
// depends on arc_pkg, arc_ctrl, arc_dp
module arp_resolver_cache_top import arc_pkg::*; #(
    parameter int CACHE_ENTRIES   = 16,
    parameter int REQUEST_ENTRIES = 8,
    parameter int QUEUE_DEPTH     = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  t_in_word    i_in_word,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output t_out_word   o_out_word,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [47:0] i_cfg_data
);

    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;

    // registers are always writable
    assign o_cfg_ready = 1'b1;

    // sequencer
    arc_ctrl #(
        .CACHE_ENTRIES  (CACHE_ENTRIES),
        .REQUEST_ENTRIES(REQUEST_ENTRIES),
        .QUEUE_DEPTH    (QUEUE_DEPTH)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    // tables and result buffers
    arc_dp #(
        .CACHE_ENTRIES  (CACHE_ENTRIES),
        .REQUEST_ENTRIES(REQUEST_ENTRIES),
        .QUEUE_DEPTH    (QUEUE_DEPTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_word   (i_in_word),
        .i_cfg_we    (i_cfg_valid & o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_cmd       (w_cmd),
        .o_stat      (w_stat),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_word  (o_out_word)
    );

endmodule

// ----- design/arc_chk.sv -----
// arc_chk: port-level checks of the arp resolver cache
// bound to arp_resolver_cache_top; depends on arc_pkg
module arc_chk import arc_pkg::*; (
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_in_valid,
    input logic      o_in_stall,
    input logic      o_out_valid,
    input logic      i_out_stall,
    input t_out_word o_out_word
);

    // output word holds while stalled
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_word))
        else $error("output word changed under stall");

    // one word at a time: an accepted word closes the input
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("input taken while busy");

    // an empty result always ends its word
    a_none_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_word.action == ACT_NONE |-> o_out_word.last)
        else $error("none result not last");

    // action codes stay in range
    a_action: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_word.action <= ACT_DROP)
        else $error("bad action code");

    // reset empties the output
    a_reset: assert property (@(posedge i_clk) !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

endmodule

bind arp_resolver_cache_top arc_chk u_arc_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_word  (o_out_word)
);
